[design/mchm_pkg.sv]
// Package for the nearest marker code matcher.
// Holds the shared widths, codes, controller types and the popcount function.
// No dependencies.
package mchm_pkg;

  localparam int unsigned WORD_W       = 40;
  localparam int unsigned CELL_W       = 36;
  localparam int unsigned ROT_N        = 4;
  localparam int unsigned ROT_W        = 2;
  localparam int unsigned ID_W         = 8;
  localparam int unsigned DIST_W       = 6;
  localparam int unsigned CFG_W        = 9;
  localparam int unsigned OP_W         = 1;

  localparam logic [DIST_W-1:0] INITIAL_BEST  = 6'd37;
  localparam logic [CFG_W-1:0]  ENTRIES_RESET = 9'd250;

  localparam logic [OP_W-1:0] OP_LOAD  = 1'b0;
  localparam logic [OP_W-1:0] OP_MATCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic start;     // latch candidate and limit, clear best and scan counter
    logic issue;     // read the next dictionary entry
    logic write;     // write one dictionary word from the input transaction
    logic out_load;  // copy the best match into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;   // every entry in use has been read
    logic pipe_empty;  // no read or distance still in flight
    logic found;       // best distance is below the initial best
  } dp_status_t;

  // Number of set bits in one packed code word.
  function automatic logic [DIST_W-1:0] popcount_word(input logic [WORD_W-1:0] v);
    logic [DIST_W-1:0] n;
    n = '0;
    for (int i = 0; i < WORD_W; i++) begin
      n = n + DIST_W'(v[i]);
    end
    return n;
  endfunction

endpackage

[design/mchm_in_if.sv]
// Input channel of the nearest marker code matcher: load and query transactions.
// Depends on mchm_pkg for the field widths.
interface mchm_in_if;
  logic                               valid;
  logic                               ready;
  logic [mchm_pkg::OP_W-1:0]          opcode;
  logic [7:0]                         entry_index;
  logic [mchm_pkg::ROT_W-1:0]         rotation_index;
  logic [mchm_pkg::WORD_W-1:0]        dict_word;
  logic [mchm_pkg::CELL_W-1:0]        candidate_bits;

  modport source (
    output valid, opcode, entry_index, rotation_index, dict_word, candidate_bits,
    input  ready
  );
  modport sink (
    input  valid, opcode, entry_index, rotation_index, dict_word, candidate_bits,
    output ready
  );
endinterface

[design/mchm_out_if.sv]
// Result channel of the nearest marker code matcher: one match per transaction.
// Depends on mchm_pkg for the field widths.
interface mchm_out_if;
  logic                          valid;
  logic                          ready;
  logic [mchm_pkg::ID_W-1:0]     match_id;
  logic [mchm_pkg::ROT_W-1:0]    match_rotation;
  logic [mchm_pkg::DIST_W-1:0]   match_distance;

  modport source (
    output valid, match_id, match_rotation, match_distance,
    input  ready
  );
  modport sink (
    input  valid, match_id, match_rotation, match_distance,
    output ready
  );
endinterface

[design/mchm_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module mchm_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/mchm_ctrl.sv]
// Controller of the nearest marker code matcher: handshakes and scan sequencing.
// Depends on mchm_pkg for the state, command and status types.
module mchm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [mchm_pkg::OP_W-1:0] in_opcode,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  mchm_pkg::dp_status_t  status,
  output mchm_pkg::dp_cmd_t     cmd
);

  mchm_pkg::ctrl_state_t state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  in_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mchm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == mchm_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign in_acc    = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      mchm_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_opcode == mchm_pkg::OP_MATCH) begin
            cmd.start = 1'b1;
            state_nxt = mchm_pkg::ST_SCAN;
          end else begin
            cmd.write = 1'b1;
          end
        end
      end
      mchm_pkg::ST_SCAN: begin
        if (status.scan_done) begin
          state_nxt = mchm_pkg::ST_DRAIN;
        end else begin
          cmd.issue = 1'b1;
        end
      end
      mchm_pkg::ST_DRAIN: begin
        if (status.pipe_empty) begin
          state_nxt = mchm_pkg::ST_FINISH;
        end
      end
      mchm_pkg::ST_FINISH: begin
        if (!status.found) begin
          state_nxt = mchm_pkg::ST_IDLE;
        end else if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = mchm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mchm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[design/mchm_dp.sv]
// Datapath of the nearest marker code matcher: dictionary RAMs, scan counter,
// distance pipeline, running minimum and output register. Uses mchm_pkg, mchm_ram.
module mchm_dp #(
  parameter int unsigned MAX_ENTRIES = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mchm_pkg::dp_cmd_t             cmd,
  output mchm_pkg::dp_status_t          status,
  input  logic [mchm_pkg::CFG_W-1:0]    entries_in_use,
  input  logic [7:0]                    entry_index,
  input  logic [mchm_pkg::ROT_W-1:0]    rotation_index,
  input  logic [mchm_pkg::WORD_W-1:0]   dict_word,
  input  logic [mchm_pkg::CELL_W-1:0]   candidate_bits,
  output logic [mchm_pkg::ID_W-1:0]     match_id,
  output logic [mchm_pkg::ROT_W-1:0]    match_rotation,
  output logic [mchm_pkg::DIST_W-1:0]   match_distance
);

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned LW = (CW > mchm_pkg::CFG_W) ? CW : mchm_pkg::CFG_W;

  localparam int unsigned DW = mchm_pkg::DIST_W;
  localparam int unsigned RN = mchm_pkg::ROT_N;
  localparam int unsigned RW = mchm_pkg::ROT_W;
  localparam int unsigned IW = mchm_pkg::ID_W;

  logic [mchm_pkg::WORD_W-1:0] cand_r;
  logic [LW-1:0]               limit_r;
  logic [LW-1:0]               cnt_r;
  logic [LW-1:0]               cfg_ext;
  logic                        wr_ok;

  logic                        s1_vld_r;
  logic [AW-1:0]               s1_idx_r;
  logic [mchm_pkg::WORD_W-1:0] rd_word [RN];

  logic                        s2_vld_r;
  logic [AW-1:0]               s2_idx_r;
  logic [RN-1:0][DW-1:0]       s2_dist_r;

  logic [DW-1:0]               best_dist_r, best_dist_nxt;
  logic [RW-1:0]               best_rot_r,  best_rot_nxt;
  logic [IW-1:0]               best_id_r,   best_id_nxt;

  logic [IW-1:0]               out_id_r;
  logic [RW-1:0]               out_rot_r;
  logic [DW-1:0]               out_dist_r;

  assign cfg_ext = LW'(entries_in_use);
  assign wr_ok   = cmd.write && (LW'(entry_index) < LW'(MAX_ENTRIES));

  // One RAM per rotation, so that all four words of an entry read together.
  for (genvar g = 0; g < RN; g++) begin : g_rot
    mchm_ram #(
      .WIDTH (mchm_pkg::WORD_W),
      .DEPTH (MAX_ENTRIES)
    ) u_ram (
      .clk     (clk),
      .wr_en   (wr_ok && (rotation_index == RW'(g))),
      .wr_addr (AW'(entry_index)),
      .wr_data (dict_word),
      .rd_en   (cmd.issue),
      .rd_addr (cnt_r[AW-1:0]),
      .rd_data (rd_word[g])
    );
  end

  // Query setup and scan counter.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cand_r  <= {candidate_bits[mchm_pkg::CELL_W-1:4], 4'b0000, candidate_bits[3:0]};
      limit_r <= (cfg_ext > LW'(MAX_ENTRIES)) ? LW'(MAX_ENTRIES) : cfg_ext;
      cnt_r   <= '0;
    end else if (cmd.issue) begin
      cnt_r   <= cnt_r + LW'(1);
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= cmd.issue;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      s1_idx_r <= cnt_r[AW-1:0];
    end
    if (s1_vld_r) begin
      s2_idx_r <= s1_idx_r;
      for (int r = 0; r < RN; r++) begin
        s2_dist_r[r] <= mchm_pkg::popcount_word(rd_word[r] ^ cand_r);
      end
    end
  end

  // Running minimum; rotations in order, strict compare keeps the first hit.
  always_comb begin
    best_dist_nxt = best_dist_r;
    best_rot_nxt  = best_rot_r;
    best_id_nxt   = best_id_r;
    if (s2_vld_r) begin
      for (int r = 0; r < RN; r++) begin
        if (s2_dist_r[r] < best_dist_nxt) begin
          best_dist_nxt = s2_dist_r[r];
          best_rot_nxt  = RW'(r);
          best_id_nxt   = IW'(s2_idx_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      best_dist_r <= mchm_pkg::INITIAL_BEST;
      best_rot_r  <= '0;
      best_id_r   <= '0;
    end else begin
      best_dist_r <= best_dist_nxt;
      best_rot_r  <= best_rot_nxt;
      best_id_r   <= best_id_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_id_r   <= best_id_r;
      out_rot_r  <= best_rot_r;
      out_dist_r <= best_dist_r;
    end
  end

  assign status.scan_done  = (cnt_r == limit_r);
  assign status.pipe_empty = !s1_vld_r && !s2_vld_r;
  assign status.found      = (best_dist_r < mchm_pkg::INITIAL_BEST);

  assign match_id       = out_id_r;
  assign match_rotation = out_rot_r;
  assign match_distance = out_dist_r;

endmodule

[design/marker_code_nearest_hamming_match.sv]
// Top level of the nearest marker code matcher.
// Depends on mchm_pkg, mchm_in_if, mchm_out_if, mchm_ctrl, mchm_dp and mchm_ram.
//
// The block holds a dictionary of up to MAX_ENTRIES marker codes, each stored as
// four 40-bit words, one per rotation. A load transaction (opcode 0) writes one
// word and leaves input ready high; an entry index at or beyond MAX_ENTRIES
// is ignored. A query transaction (opcode 1) packs its 6x6 cell matrix into the
// five-byte code layout and scans entries 0 to entries_in_use-1, reading one
// entry per cycle from the dictionary RAMs and comparing all four rotations of
// it at once. The result carries the first entry and rotation at the smallest
// Hamming distance. A query occupies the block from its acceptance until its
// scan, paced by the single read port of the dictionary (one entry per cycle),
// and the short read/popcount/compare pipeline behind it are done, and for as
// long as an earlier result still waits in the output register before its own
// result can be loaded; input ready is low for the whole scan. When no
// word lies below the initial best of 37 (only possible with pad bits set in
// stored words), or when entries_in_use is zero, no result transaction is
// produced. entries_in_use above MAX_ENTRIES is treated as MAX_ENTRIES, and its
// reset value is 250. The result sits in an output register, so load
// transactions are taken while a finished result waits to be collected. Every
// entry that a query scans must have all four words loaded beforehand; the
// dictionary has no reset.
module marker_code_nearest_hamming_match #(
  parameter int unsigned MAX_ENTRIES = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  mchm_in_if.sink                    in_ch,
  mchm_out_if.source                 out_ch,
  input  logic                       cfg_wr_en,
  input  logic [mchm_pkg::CFG_W-1:0] cfg_wr_data
);

  logic [mchm_pkg::CFG_W-1:0] entries_r;
  mchm_pkg::dp_cmd_t          cmd;
  mchm_pkg::dp_status_t       status;

  // Configuration register: the number of entries a query scans.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= mchm_pkg::ENTRIES_RESET;
    end else if (cfg_wr_en) begin
      entries_r <= cfg_wr_data;
    end
  end

  // The controller owns both handshakes and steps the datapath through a scan.
  mchm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_opcode (in_ch.opcode),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the dictionary, the distance pipeline and the result.
  mchm_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .entries_in_use (entries_r),
    .entry_index    (in_ch.entry_index),
    .rotation_index (in_ch.rotation_index),
    .dict_word      (in_ch.dict_word),
    .candidate_bits (in_ch.candidate_bits),
    .match_id       (out_ch.match_id),
    .match_rotation (out_ch.match_rotation),
    .match_distance (out_ch.match_distance)
  );

endmodule

[design/mchm_checker.sv]
// Port-level checker for the nearest marker code matcher, with its bind.
// Depends on mchm_pkg and the top level marker_code_nearest_hamming_match.
module mchm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [mchm_pkg::OP_W-1:0]     in_opcode,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [mchm_pkg::ID_W-1:0]     match_id,
  input logic [mchm_pkg::ROT_W-1:0]    match_rotation,
  input logic [mchm_pkg::DIST_W-1:0]   match_distance
);

  logic query_acc;
  assign query_acc = in_valid && in_ready && (in_opcode == mchm_pkg::OP_MATCH);

  // A result waiting to be taken keeps its transaction intact.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(match_id) &&
      $stable(match_rotation) && $stable(match_distance))
    else $error("result transaction changed while stalled");

  // No result is offered in the cycle after reset.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A query blocks the input channel while its scan starts.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    query_acc |=> !in_ready)
    else $error("input ready directly after a query");

  // A query cannot produce a result in the very next cycle.
  a_query_latency: assert property (@(posedge clk) disable iff (!rst_n)
    query_acc |=> !$rose(out_valid))
    else $error("result appeared too early after a query");

endmodule

bind marker_code_nearest_hamming_match mchm_checker u_mchm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_opcode      (in_ch.opcode),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .match_id       (out_ch.match_id),
  .match_rotation (out_ch.match_rotation),
  .match_distance (out_ch.match_distance)
);
